FILE: hw/rtl/cartridge_bank_switch_mapper_top_macros.svh
// Assertion macros shared by the cartridge bank mapper RTL.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CBSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cbsm_pkg.sv
// Types, constants and helpers for the cartridge bank mapper.
package cbsm_pkg;

    localparam int BANK_REGS = 8;
    localparam int BANK_IDX_W = $clog2(BANK_REGS);

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CPU   = 2'd1;
    localparam logic [1:0] OP_PPU   = 2'd2;

    // mirroring codes
    localparam logic [1:0] MIR_VERT = 2'd0;
    localparam logic [1:0] MIR_HORZ = 2'd1;
    localparam logic [1:0] MIR_FOUR = 2'd2;

    // register write decode
    localparam logic [15:0] WR_DEC_MASK    = 16'hE001;
    localparam logic [15:0] WR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] WR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] WR_MIRROR      = 16'hA000;

    localparam logic [7:0] SLOT_2K_MASK  = 8'hFE;
    localparam logic [7:0] PRG0_LIMIT    = 8'h50;
    localparam logic [7:0] PRG0_MASK     = 8'h4F;
    localparam logic [2:0] SEL_MASK      = 3'h7;
    localparam logic [2:0] SLOT_PRG0     = 3'd6;
    localparam logic [2:0] SLOT_PRG1     = 3'd7;
    localparam int         BS_PRG_SWAP   = 6;
    localparam int         BS_CHR_SWAP   = 7;

    // configuration register indexes
    localparam logic [1:0] REG_PRG_LOG2    = 2'd0;
    localparam logic [1:0] REG_CHR_LOG2    = 2'd1;
    localparam logic [1:0] REG_CHR_PRESENT = 2'd2;
    localparam logic [1:0] REG_FOUR_SCREEN = 2'd3;

    localparam logic [3:0] LOG2_RESET = 4'd8;
    localparam logic [3:0] LOG2_MAX   = 4'd8;

    localparam logic [7:0] BANK_RESET [BANK_REGS] = '{
        8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_cmd;

    // Bank-count mask, saturated at 256 banks.
    function automatic logic [7:0] count_mask(input logic [3:0] log2v);
        logic [8:0] one_hot;
        one_hot = 9'd0;
        if (log2v >= LOG2_MAX) begin
            return 8'hFF;
        end
        one_hot[log2v] = 1'b1;
        return 8'(one_hot - 9'd1);
    endfunction

endpackage

FILE: hw/rtl/cartridge_bank_switch_mapper_top.sv
// Cartridge bank mapper top level: stream pipeline and configuration port.
// Each beat is a bank register write, a CPU read translation or a PPU pattern
// read translation, and yields exactly one result beat. One beat is taken per
// clock while s_axis_tready is high; each beat passes the input register and
// then the result register, with the register update and translation logic
// between them. s_axis_tready drops only while a held result blocks the
// input register. Results report mirroring as it stands after that beat's
// own write. Write the configuration registers only while no beat is in flight.
`include "cartridge_bank_switch_mapper_top_macros.svh"

module cartridge_bank_switch_mapper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // rom_address[20:0], address_mapped[21],
                                        // mirroring[23:22]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_in_valid;
    cbsm_pkg::t_cmd  r_in_cmd;
    logic            r_out_valid;
    logic [23:0]     r_out_data;

    logic [3:0]      r_prg_log2, r_chr_log2;
    logic            r_chr_present, r_four_screen;

    logic            w_out_free, w_commit, w_cfg_wr;
    logic [cbsm_pkg::BANK_IDX_W-1:0] w_rd_idx;
    logic [7:0]      w_bank_select, w_rd_bank;
    logic            w_hmirror_next;
    logic [20:0]     w_rom_address;
    logic            w_mapped;
    logic [1:0]      w_mirroring;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_commit      = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd.opcode     <= s_axis_tuser;
            r_in_cmd.address    <= s_axis_tdata[15:0];
            r_in_cmd.write_data <= s_axis_tdata[23:16];
        end
    end

    cbsm_bank_regs u_bank_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_commit       (w_commit),
        .i_cmd          (r_in_cmd),
        .i_four_screen  (r_four_screen),
        .i_rd_idx       (w_rd_idx),
        .o_bank_select  (w_bank_select),
        .o_rd_bank      (w_rd_bank),
        .o_hmirror_next (w_hmirror_next)
    );

    cbsm_xlate u_xlate (
        .i_cmd         (r_in_cmd),
        .i_bank_select (w_bank_select),
        .i_rd_bank     (w_rd_bank),
        .i_prg_log2    (r_prg_log2),
        .i_chr_log2    (r_chr_log2),
        .i_chr_present (r_chr_present),
        .o_rd_idx      (w_rd_idx),
        .o_rom_address (w_rom_address),
        .o_mapped      (w_mapped)
    );

    assign w_mirroring = r_four_screen ? cbsm_pkg::MIR_FOUR
                       : (w_hmirror_next ? cbsm_pkg::MIR_HORZ : cbsm_pkg::MIR_VERT);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {w_mirroring, w_mapped, w_rom_address};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_log2    <= cbsm_pkg::LOG2_RESET;
            r_chr_log2    <= cbsm_pkg::LOG2_RESET;
            r_chr_present <= 1'b1;
            r_four_screen <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                cbsm_pkg::REG_PRG_LOG2:    r_prg_log2    <= pwdata[3:0];
                cbsm_pkg::REG_CHR_LOG2:    r_chr_log2    <= pwdata[3:0];
                cbsm_pkg::REG_CHR_PRESENT: r_chr_present <= pwdata[0];
                default:                   r_four_screen <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cbsm_pkg::REG_PRG_LOG2:    prdata = {28'd0, r_prg_log2};
            cbsm_pkg::REG_CHR_LOG2:    prdata = {28'd0, r_chr_log2};
            cbsm_pkg::REG_CHR_PRESENT: prdata = {31'd0, r_chr_present};
            default:                   prdata = {31'd0, r_four_screen};
        endcase
    end

    `CBSM_ASSERT_NEXT(a_write_result_zero, w_commit && r_in_cmd.opcode == cbsm_pkg::OP_WRITE, m_axis_tdata[21:0] == 22'd0, "write beat gave a nonzero translation")
    `CBSM_ASSERT_NEXT(a_ppu_range, w_commit && r_in_cmd.opcode == cbsm_pkg::OP_PPU, m_axis_tdata[20:18] == 3'd0, "pattern address beyond 256K")
    `CBSM_ASSERT_NEXT(a_four_screen, w_commit && r_four_screen, m_axis_tdata[23:22] == cbsm_pkg::MIR_FOUR, "four-screen not reported")
    `CBSM_ASSERT_SAME(a_commit_fills, w_commit, !r_out_valid || m_axis_tready, "result register overwritten while held")

endmodule

FILE: hw/rtl/cbsm_bank_regs.sv
// Bank-select, bank value and mirroring registers with the write decoder.
module cbsm_bank_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  cbsm_pkg::t_cmd                i_cmd,
    input  logic                          i_four_screen,
    input  logic [cbsm_pkg::BANK_IDX_W-1:0] i_rd_idx,
    output logic [7:0]                    o_bank_select,
    output logic [7:0]                    o_rd_bank,
    output logic                          o_hmirror_next
);

    logic [7:0] r_bank_select, n_bank_select;
    logic [7:0] r_bank [cbsm_pkg::BANK_REGS];
    logic       r_hmirror, n_hmirror;
    logic       w_bank_we;
    logic [cbsm_pkg::BANK_IDX_W-1:0] w_sel;
    logic [7:0] w_bank_data;
    logic [15:0] w_dec;

    assign w_dec = i_cmd.address & cbsm_pkg::WR_DEC_MASK;
    assign w_sel = r_bank_select[cbsm_pkg::BANK_IDX_W-1:0] & cbsm_pkg::SEL_MASK;

    always_comb begin
        n_bank_select = r_bank_select;
        n_hmirror     = r_hmirror;
        w_bank_we     = 1'b0;
        w_bank_data   = i_cmd.write_data;
        if (w_sel <= 3'd1) begin
            w_bank_data = i_cmd.write_data & cbsm_pkg::SLOT_2K_MASK;
        end else if (w_sel == cbsm_pkg::SLOT_PRG0 && i_cmd.write_data >= cbsm_pkg::PRG0_LIMIT) begin
            w_bank_data = i_cmd.write_data & cbsm_pkg::PRG0_MASK;
        end
        if (i_commit && i_cmd.opcode == cbsm_pkg::OP_WRITE) begin
            if (w_dec == cbsm_pkg::WR_BANK_SELECT) begin
                n_bank_select = i_cmd.write_data;
            end else if (w_dec == cbsm_pkg::WR_BANK_DATA) begin
                w_bank_we = 1'b1;
            end else if (w_dec == cbsm_pkg::WR_MIRROR && !i_four_screen) begin
                n_hmirror = i_cmd.write_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= 8'd0;
            r_hmirror     <= 1'b0;
            for (int i = 0; i < cbsm_pkg::BANK_REGS; i++) begin
                r_bank[i] <= cbsm_pkg::BANK_RESET[i];
            end
        end else begin
            r_bank_select <= n_bank_select;
            r_hmirror     <= n_hmirror;
            if (w_bank_we) begin
                r_bank[w_sel] <= w_bank_data;
            end
        end
    end

    assign o_bank_select  = r_bank_select;
    assign o_rd_bank      = r_bank[i_rd_idx];
    assign o_hmirror_next = n_hmirror;

endmodule

FILE: hw/rtl/cbsm_xlate.sv
// CPU and PPU address translation through the bank registers.
module cbsm_xlate (
    input  cbsm_pkg::t_cmd                  i_cmd,
    input  logic [7:0]                      i_bank_select,
    input  logic [7:0]                      i_rd_bank,
    input  logic [3:0]                      i_prg_log2,
    input  logic [3:0]                      i_chr_log2,
    input  logic                            i_chr_present,
    output logic [cbsm_pkg::BANK_IDX_W-1:0] o_rd_idx,
    output logic [20:0]                     o_rom_address,
    output logic                            o_mapped
);

    logic [1:0] w_prg_slot;
    logic [2:0] w_chr_slot;
    logic [7:0] w_prg_mask, w_chr_mask;
    logic [7:0] w_prg_bank, w_chr_bank;

    assign w_prg_mask = cbsm_pkg::count_mask(i_prg_log2);
    assign w_chr_mask = cbsm_pkg::count_mask(i_chr_log2);

    always_comb begin
        w_prg_slot = i_cmd.address[14:13];
        if (i_bank_select[cbsm_pkg::BS_PRG_SWAP] && !w_prg_slot[0]) begin
            w_prg_slot = w_prg_slot ^ 2'd2;
        end
        w_chr_slot = i_cmd.address[12:10];
        if (i_bank_select[cbsm_pkg::BS_CHR_SWAP]) begin
            w_chr_slot = w_chr_slot ^ 3'd4;
        end
    end

    // one bank lookup per item: program slot or pattern slot
    always_comb begin
        if (i_cmd.opcode == cbsm_pkg::OP_CPU) begin
            o_rd_idx = w_prg_slot[0] ? cbsm_pkg::SLOT_PRG1 : cbsm_pkg::SLOT_PRG0;
        end else if (!w_chr_slot[2]) begin
            o_rd_idx = {2'b00, w_chr_slot[1]};
        end else begin
            o_rd_idx = w_chr_slot - 3'd2;
        end
    end

    always_comb begin
        unique case (w_prg_slot)
            2'd0, 2'd1: w_prg_bank = i_rd_bank & w_prg_mask;
            2'd2:       w_prg_bank = (w_prg_mask - 8'd1) & w_prg_mask;
            default:    w_prg_bank = w_prg_mask;
        endcase
        if (!w_chr_slot[2]) begin
            w_chr_bank = (i_rd_bank | {7'd0, w_chr_slot[0]}) & w_chr_mask;
        end else begin
            w_chr_bank = i_rd_bank & w_chr_mask;
        end
    end

    always_comb begin
        o_rom_address = 21'd0;
        o_mapped      = 1'b0;
        unique case (i_cmd.opcode)
            cbsm_pkg::OP_CPU: begin
                if (i_cmd.address[15]) begin
                    o_mapped      = 1'b1;
                    o_rom_address = {w_prg_bank, i_cmd.address[12:0]};
                end
            end
            cbsm_pkg::OP_PPU: begin
                if (i_chr_present && i_cmd.address[15:13] == 3'd0) begin
                    o_mapped      = 1'b1;
                    o_rom_address = {3'd0, w_chr_bank, i_cmd.address[9:0]};
                end
            end
            default: begin
                o_rom_address = 21'd0;
                o_mapped      = 1'b0;
            end
        endcase
    end

endmodule
